[design/fre_pkg.sv]
// Shared types and codes for the free rectangle expansion block.
package fre_pkg;

  // Width of the configuration registers and of the widened row and column indexes.
  localparam int CFG_W = 7;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Request codes.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_EXPAND = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FETCH = 8'b0000_0010,
    ST_RIGHT = 8'b0000_0100,
    ST_LEFT  = 8'b0000_1000,
    ST_SPAN  = 8'b0001_0000,
    ST_DOWN  = 8'b0010_0000,
    ST_UP    = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

endpackage

[design/free_rectangle_expansion.sv]
// Top level of the free rectangle expansion block: sequencer, bit probe and row checks.
//
// The block keeps an occupancy grid, one word of free bits per row, in a small
// row memory. A beat is accepted on start while busy is low. A load beat
// (req_type low) writes row_bits into row pos_y in that same edge and gives no
// result; busy stays low, so loads may come back to back. An expand beat
// (req_type high) raises busy and runs the sequencer: it fetches the start
// row, probes the columns one at a time while the run grows right and then
// left, forms the column mask, then reads one row per cycle while the span
// grows down and then up, and presents the result; busy drops in the cycle
// after it. The single column probe and one memory read per cycle pace the
// growth. A blocked start, or a start outside the grid in use, finishes
// straight after the fetch, with start_blocked high and the start cell as
// the rectangle. The result is shown on the rect ports for exactly one
// cycle, marked by done; the receiver cannot stall, so nothing is held back.
// Configuration writes through cfg_we take effect at the next expand; the
// user must see that they are made only while busy is low, as the block
// does not enforce this. Reset sets both grid sizes to their maximum and
// returns the sequencer to idle; the grid rows stay undefined until loaded.
module free_rectangle_expansion #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type,
  input  logic [5:0]               pos_x,
  input  logic [5:0]               pos_y,
  input  logic [63:0]              row_bits,
  output logic                     done,
  output logic [5:0]               rect_left,
  output logic [5:0]               rect_top,
  output logic [5:0]               rect_right,
  output logic [5:0]               rect_bottom,
  output logic                     start_blocked,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [fre_pkg::CFG_W-1:0] cfg_data
);

  import fre_pkg::*;

  // Only 64 rows can ever be addressed, so storage stops there.
  localparam int DEPTH  = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = MAX_WIDTH;

  state_t state, state_next;

  logic [CFG_W-1:0] grid_width, grid_height;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [CFG_W-1:0] w_q, h_q;

  logic [5:0] x_q, y_q;
  logic [5:0] l, r, t, b;
  logic       blocked;

  logic [ROW_W-1:0] row_reg;
  logic [ROW_W-1:0] span;
  logic [ROW_W-1:0] rd_data;

  logic [CFG_W-1:0] rd_idx;
  logic [ROW_W-1:0] probe_row;
  logic [CFG_W-1:0] probe_col;
  logic [ROW_W-1:0] probe_shift;
  logic             probe_bit;
  logic             row_ok;
  logic             start_bad;
  logic             accept;
  logic             wr_en;

  logic [CFG_W-1:0] x7, y7, r1, l1, b2;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);

  assign x7 = {1'b0, x_q};
  assign y7 = {1'b0, y_q};
  assign r1 = {1'b0, r} + CFG_W'(1);
  assign l1 = {1'b0, l} - CFG_W'(1);
  assign b2 = {1'b0, b} + CFG_W'(2);

  // Registers out of range are clamped to the sizes the hardware holds.
  always_comb begin
    if (grid_width == '0) begin
      w_eff = CFG_W'(1);
    end else if (grid_width > CFG_W'(MAX_WIDTH)) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (grid_height > CFG_W'(DEPTH)) begin
      h_eff = CFG_W'(DEPTH);
    end else begin
      h_eff = grid_height;
    end
  end

  // The shared probe: one bit of one row per cycle.
  assign probe_shift = probe_row >> probe_col;
  assign probe_bit   = probe_shift[0];

  // A row extends the rectangle when every column of the span is free in it.
  assign row_ok = ((rd_data & span) == span);

  assign start_bad = (x7 >= w_q) || (y7 >= h_q) || !probe_bit;

  // Loads go straight into the row memory; rows past storage are dropped.
  assign wr_en = accept && (req_type == REQ_LOAD) && ({1'b0, pos_y} < CFG_W'(DEPTH));

  fre_row_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ROW_W)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_y[ADDR_W-1:0]),
    .wr_data (row_bits[ROW_W-1:0]),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Sequencer: next state, the read address ahead of its use, and the probe select.
  always_comb begin
    state_next = state;
    rd_idx     = y7;
    probe_row  = row_reg;
    probe_col  = r1;
    unique case (state)
      ST_IDLE: begin
        rd_idx = {1'b0, pos_y};
        if (accept && (req_type == REQ_EXPAND)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        probe_row = rd_data;
        probe_col = x7;
        state_next = start_bad ? ST_DONE : ST_RIGHT;
      end
      ST_RIGHT: begin
        probe_col = r1;
        if (!((r1 < w_q) && probe_bit)) begin
          state_next = ST_LEFT;
        end
      end
      ST_LEFT: begin
        probe_col = l1;
        if (!((l != '0) && probe_bit)) begin
          state_next = ST_SPAN;
        end
      end
      ST_SPAN: begin
        if (y7 + CFG_W'(1) < h_q) begin
          rd_idx     = y7 + CFG_W'(1);
          state_next = ST_DOWN;
        end else if (y_q != '0) begin
          rd_idx     = y7 - CFG_W'(1);
          state_next = ST_UP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DOWN: begin
        if (row_ok && (b2 < h_q)) begin
          rd_idx = b2;
        end else if (y_q != '0) begin
          rd_idx     = y7 - CFG_W'(1);
          state_next = ST_UP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_UP: begin
        if (row_ok && (t > 6'd1)) begin
          rd_idx = {1'b0, t} - CFG_W'(2);
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      grid_width  <= CFG_W'(64);
      grid_height <= CFG_W'(64);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  grid_width  <= cfg_data;
          REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Working registers of one expand; they need no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          x_q <= pos_x;
          y_q <= pos_y;
          w_q <= w_eff;
          h_q <= h_eff;
        end
      end
      ST_FETCH: begin
        row_reg <= rd_data;
        blocked <= start_bad;
        l       <= x_q;
        r       <= x_q;
        t       <= y_q;
        b       <= y_q;
      end
      ST_RIGHT: begin
        if ((r1 < w_q) && probe_bit) begin
          r <= r1[5:0];
        end
      end
      ST_LEFT: begin
        if ((l != '0) && probe_bit) begin
          l <= l1[5:0];
        end
      end
      ST_SPAN: begin
        for (int i = 0; i < ROW_W; i++) begin
          span[i] <= (CFG_W'(i) >= {1'b0, l}) && (CFG_W'(i) <= {1'b0, r});
        end
      end
      ST_DOWN: begin
        if (row_ok) begin
          b <= b + 6'd1;
        end
      end
      ST_UP: begin
        if (row_ok) begin
          t <= t - 6'd1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign rect_left     = l;
  assign rect_right    = r;
  assign rect_top      = t;
  assign rect_bottom   = b;
  assign start_blocked = blocked;

`ifndef ASSERT_OFF
  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state is not one-hot");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block did not return to idle after a result");

  a_blocked_is_cell: assert property (@(posedge clk) disable iff (rst)
    (done && start_blocked) |-> (rect_left == rect_right) && (rect_top == rect_bottom))
    else $error("blocked result is not a single cell");

  a_rect_ordered: assert property (@(posedge clk) disable iff (rst)
    (done && !start_blocked) |-> (rect_left <= rect_right) && (rect_top <= rect_bottom))
    else $error("rectangle corners out of order");

  a_start_inside: assert property (@(posedge clk) disable iff (rst)
    done |-> (rect_left <= x_q) && (x_q <= rect_right) && (rect_top <= y_q) &&
             (y_q <= rect_bottom))
    else $error("rectangle does not hold the start cell");
`endif

endmodule

[design/fre_row_mem.sv]
// Grid row storage: one write port and one registered read port.
module fre_row_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // The read port runs every cycle; the sequencer picks the address ahead of its use.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the free rectangle expansion block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fre_pkg::*;

  // One beat on the command side: a row load or an expand request.
  typedef struct {
    logic        kind;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [63:0] bits;
  } beat_t;

  // One rectangle as the block reports it.
  typedef struct packed {
    logic [5:0] left;
    logic [5:0] top;
    logic [5:0] right;
    logic [5:0] bottom;
    logic       blocked;
  } rect_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type = REQ_LOAD;
  logic [5:0]        pos_x = '0;
  logic [5:0]        pos_y = '0;
  logic [63:0]       row_bits = '0;
  logic              done;
  logic [5:0]        rect_left;
  logic [5:0]        rect_top;
  logic [5:0]        rect_right;
  logic [5:0]        rect_bottom;
  logic              start_blocked;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_GRID_WIDTH;
  logic [CFG_W-1:0]  cfg_data = '0;

  free_rectangle_expansion dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .row_bits      (row_bits),
    .done          (done),
    .rect_left     (rect_left),
    .rect_top      (rect_top),
    .rect_right    (rect_right),
    .rect_bottom   (rect_bottom),
    .start_blocked (start_blocked),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Beats waiting to be driven, and rectangles the block still owes us.
  beat_t      pend_q[$];
  rect_t      rect_q[$];

  // Our own copy of the block state: the free map as of the last accepted load,
  // and the two size registers as last written. plan_map tracks the map as it
  // will be once every queued load is taken, so that the stimulus can aim
  // expand starts at cells that are actually free.
  bit [63:0]  free_map [64];
  bit [63:0]  plan_map [64];
  logic [6:0] cols_reg = 7'd64;
  logic [6:0] rows_reg = 7'd64;

  int         fail_cnt = 0;
  int         beats_queued = 0;
  int         hold_off = 0;
  bit         gaps_on = 1'b0;
  beat_t      cur;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result; this is several times
  // the slowest legal run (every beat a full-grid expand after a maximal gap).
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Size registers as the block uses them: zero counts as one, anything above
  // 64 saturates at 64.
  function automatic int clamp_dim(input logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  // Greedy rectangle growth: the run in the start row grows right, then left,
  // then the column span grows down and last up while the whole span is free.
  // A start outside the grid in use, or on a blocked cell, gives the start
  // cell itself with the blocked flag set.
  function automatic rect_t grow_rect(input logic [5:0] x, input logic [5:0] y);
    int         w;
    int         h;
    int         l;
    int         r;
    int         t;
    int         b;
    bit [63:0]  line;
    bit [63:0]  span;
    rect_t      res;
    w = clamp_dim(cols_reg);
    h = clamp_dim(rows_reg);
    line = free_map[y];
    if (x >= w || y >= h || !line[x]) begin
      res = '{x, y, x, y, 1'b1};
      return res;
    end
    r = x;
    while (r + 1 < w && line[r + 1]) r++;
    l = x;
    while (l > 0 && line[l - 1]) l--;
    span = '0;
    for (int i = l; i <= r; i++) span[i] = 1'b1;
    b = y;
    while (b + 1 < h && (free_map[b + 1] & span) == span) b++;
    t = y;
    while (t > 0 && (free_map[t - 1] & span) == span) t--;
    res = '{l[5:0], t[5:0], r[5:0], b[5:0], 1'b0};
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // A row derived from the phase's base pattern with a sprinkle of blocked
  // cells; k sets how sparse the blockers are. Now and then a row is fully
  // free, fully blocked or plain noise so that vertical growth stops in
  // different ways.
  function automatic logic [63:0] make_row(input logic [63:0] base, input int k);
    logic [63:0] noise;
    noise = rand_word();
    repeat (k) noise &= rand_word();
    case ($urandom_range(0, 11))
      0:       return '1;
      1:       return '0;
      2:       return rand_word();
      default: return base & ~noise;
    endcase
  endfunction

  task automatic push_load(input int y, input logic [63:0] bits);
    beat_t bt;
    bt = '{REQ_LOAD, 6'($urandom_range(0, 63)), 6'(y), bits};
    plan_map[y] = bits;
    pend_q.insert(pend_q.size(), bt);
    beats_queued++;
  endtask

  // Expand beats carry random row_bits, since the block must ignore row_bits
  // on an expand.
  task automatic push_expand(input int x, input int y);
    beat_t bt;
    bt = '{REQ_EXPAND, 6'(x), 6'(y), rand_word()};
    pend_q.insert(pend_q.size(), bt);
    beats_queued++;
  endtask

  // Registers may only change while the block is idle: every queued beat has
  // gone out, every owed rectangle has come back, and any trailing load has
  // certainly landed.
  task automatic wait_idle();
    do @(posedge clk);
    while (pend_q.size() != 0 || start || busy || rect_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRID_WIDTH) cols_reg = val;
    else rows_reg = val;
  endtask

  task automatic set_grid(input logic [6:0] w, input logic [6:0] h);
    wait_idle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
  endtask

  // Command driver. A beat is taken at an edge where start is high and busy is
  // low; at that edge the predictor sees it, in acceptance order, so loads and
  // expands interleave exactly as the block sees them. After each beat, with
  // gaps_on set, the driver may hold start low before raising it again.
  always @(posedge clk) begin : drive_p
    logic fire;
    if (rst) begin
      start    <= 1'b0;
      hold_off <= 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        if (cur.kind == REQ_LOAD) free_map[cur.row] = cur.bits;
        else rect_q.insert(rect_q.size(), grow_rect(cur.col, cur.row));
      end
      if (!start || fire) begin
        if (hold_off != 0) begin
          hold_off <= hold_off - 1;
          start    <= 1'b0;
        end else if (pend_q.size() != 0) begin
          cur       = pend_q.pop_front();
          req_type <= cur.kind;
          pos_x    <= cur.col;
          pos_y    <= cur.row;
          row_bits <= cur.bits;
          start    <= 1'b1;
          hold_off <= gaps_on ? $urandom_range(0, 3) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result checker. done marks a one-cycle result beat; it is compared against
  // the oldest rectangle still owed.
  always @(posedge clk) begin : check_p
    rect_t got;
    rect_t want;
    if (!rst && done) begin
      got = '{rect_left, rect_top, rect_right, rect_bottom, start_blocked};
      if (rect_q.size() == 0) begin
        note_fail($sformatf("unexpected result l=%0d t=%0d r=%0d b=%0d blk=%0b",
                            got.left, got.top, got.right, got.bottom, got.blocked));
      end else begin
        want = rect_q.pop_front();
        if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
            got.bottom !== want.bottom || got.blocked !== want.blocked)
          note_fail($sformatf("rect mismatch exp l=%0d t=%0d r=%0d b=%0d blk=%0b got l=%0d t=%0d r=%0d b=%0d blk=%0b",
                              want.left, want.top, want.right, want.bottom, want.blocked,
                              got.left, got.top, got.right, got.bottom, got.blocked));
      end
    end
  end

  initial begin : stim_p
    int          w;
    int          h;
    int          k;
    int          lo;
    int          n;
    int          x;
    int          y;
    int          phase;
    logic [63:0] base;
    logic [6:0]  w_reg;
    logic [6:0]  h_reg;
    logic [6:0]  w_list [8];
    logic [6:0]  h_list [8];

    w_list = '{7'd64, 7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd63, 7'd65};
    h_list = '{7'd64, 7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd63, 7'd3};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The whole map is written first so that no expand can
    // ever reach a row that was never loaded.
    set_grid(7'd64, 7'd64);
    for (int i = 0; i < 64; i++) push_load(i, '1);
    push_expand(0, 0);                       // whole grid free, corner to corner
    push_expand(63, 63);
    push_load(31, ~(64'd1 << 40));
    push_expand(40, 31);                     // start on a blocked cell
    push_expand(40, 0);                      // downward growth stops above it
    push_expand(10, 31);                     // run stops at the blocker on the right
    push_load(0, '0);
    push_expand(5, 1);                       // upward growth stops at an empty top row
    push_load(63, {1'b1, 62'd0, 1'b1});
    push_expand(0, 63);                      // one-cell runs on both grid edges
    push_expand(63, 63);
    set_grid(7'd0, 7'd127);                  // width zero acts as one, height saturates
    push_expand(0, 5);
    push_expand(1, 5);                       // column outside the grid in use
    set_grid(7'd127, 7'd0);                  // width saturates, height zero acts as one
    push_expand(3, 0);
    push_expand(3, 1);                       // row outside the grid in use
    set_grid(7'd17, 7'd9);
    push_load(4, '1);
    push_expand(10, 4);                      // free bits past the width are not used
    push_expand(16, 8);
    push_expand(17, 0);
    push_expand(0, 9);

    // Random phases: each picks sizes, a base pattern and a blocker density,
    // rewrites a band of rows, then fires expands mostly at free cells inside
    // the grid so that all four growth steps get exercised.
    phase = 0;
    while (beats_queued < 1900) begin
      if (phase < 8) begin
        w_reg = w_list[phase];
        h_reg = h_list[phase];
      end else begin
        case ($urandom_range(0, 9))
          0:       w_reg = 7'd0;
          1:       w_reg = 7'($urandom_range(65, 127));
          2, 3:    w_reg = 7'($urandom_range(1, 8));
          default: w_reg = 7'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 9))
          0:       h_reg = 7'd0;
          1:       h_reg = 7'($urandom_range(65, 127));
          2, 3:    h_reg = 7'($urandom_range(1, 8));
          default: h_reg = 7'($urandom_range(1, 64));
        endcase
      end
      phase++;
      set_grid(w_reg, h_reg);
      gaps_on = ($urandom_range(0, 3) != 0);
      w = clamp_dim(cols_reg);
      h = clamp_dim(rows_reg);
      k = $urandom_range(1, 5);
      case ($urandom_range(0, 3))
        0: base = '1;
        1: base = ~(rand_word() & rand_word() & rand_word());
        2: begin
          lo = $urandom_range(0, 63);
          n  = $urandom_range(lo, 63);
          base = '0;
          for (int i = lo; i <= n; i++) base[i] = 1'b1;
        end
        default: base = rand_word() | rand_word();
      endcase

      lo = $urandom_range(0, 63);
      n  = $urandom_range(4, 64);
      for (int i = 0; i < n; i++) push_load((lo + i) % 64, make_row(base, k));

      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 9) == 0) begin
          push_load($urandom_range(0, 63), make_row(base, k));
        end else if ($urandom_range(0, 6) == 0) begin
          push_expand($urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
          x = $urandom_range(0, w - 1);
          y = $urandom_range(0, h - 1);
          for (int t = 0; t < 8 && !plan_map[y][x]; t++) begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
          end
          push_expand(x, y);
        end
      end
    end

    // Drain: every beat taken, every rectangle back, then a wait longer than any
    // expand, so that a stray extra result would still be caught.
    while (pend_q.size() != 0 || start || rect_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
